// ===== hdl/trm_pkg.sv =====
// Shared constants, payload types and back-end state codes for the true RMS meter.
package trm_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_SAMPLES  = 1024;
  localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
  localparam int SQ_W         = 2 * SAMPLE_BITS;
  localparam int SUM_W        = SQ_W - 2 + CNT_W;
  localparam int ROOT_W       = SAMPLE_BITS;
  localparam int RAD_W        = 2 * ROOT_W;
  localparam int RMS_W        = 16;
  localparam int COUNT_OUT_W  = 11;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QLVL_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } item_t;

  typedef struct packed {
    logic [RMS_W-1:0]       rms;
    logic [COUNT_OUT_W-1:0] sample_count;
    logic                   overflow;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_SQRT,
    B_HOLD
  } back_state_t;

endpackage

// ===== hdl/trm_front.sv =====
// Front end: takes samples, squares and accumulates them, closes a window into a job.
module trm_front import trm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  input  logic [QLVL_W-1:0] level,
  output logic              push,
  output job_t              job
);

  logic [CNT_W-1:0]        count;
  logic                    ovf;
  logic                    sq_valid;
  logic                    sq_last;
  logic [SQ_W-1:0]         sq;
  logic [CNT_W-1:0]        job_count;
  logic                    job_ovf;
  logic [SUM_W-1:0]        sum;
  logic [SUM_W-1:0]        sum_add;
  logic signed [SQ_W-1:0]  prod;
  logic [QLVL_W:0]         pend;
  logic                    accept;
  logic                    take;

  // a closing window in the square stage already owns a queue slot
  assign pend       = {1'b0, level} + {{QLVL_W{1'b0}}, sq_valid & sq_last};
  assign item_ready = pend < (QLVL_W + 1)'(QUEUE_DEPTH);
  assign accept     = item_valid & item_ready;
  assign take       = count < CNT_W'(MAX_SAMPLES);
  assign prod       = item.sample * item.sample;
  assign sum_add    = sum + SUM_W'(sq);

  assign push = sq_valid & sq_last;
  assign job  = '{sum: sum_add, count: job_count, overflow: job_ovf};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf      <= 1'b0;
      sq_valid <= 1'b0;
      sum      <= '0;
    end else begin
      sq_valid <= accept;
      if (accept) begin
        if (item.last) begin
          count <= '0;
          ovf   <= 1'b0;
        end else if (take) begin
          count <= count + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (sq_valid) begin
        sum <= sq_last ? '0 : sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq        <= take ? SQ_W'(unsigned'(prod)) : '0;
      sq_last   <= item.last;
      job_count <= take ? count + 1'b1 : count;
      job_ovf   <= ovf | ~take;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SAMPLES))
    else $error("window count past limit");
`endif

endmodule

// ===== hdl/trm_queue.sv =====
// Two-entry job queue between the sample front end and the divide/root back end.
module trm_queue import trm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  job_t              push_job,
  output logic [QLVL_W-1:0] level,
  output logic              head_valid,
  input  logic              pop,
  output job_t              head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign head_valid = level != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> level < QLVL_W'(QUEUE_DEPTH))
    else $error("job pushed into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> level != '0)
    else $error("job popped from empty queue");
`endif

endmodule

// ===== hdl/trm_back.sv =====
// Back end: restoring divide of the sum by the count, then a bit-pair square root.
module trm_back import trm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  output logic    job_ready,
  input  job_t    job,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int STEP_W = $clog2(SUM_W);

  back_state_t       state;
  back_state_t       state_next;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  divisor;
  logic [CNT_W-1:0]  rem_d;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  j_count;
  logic              j_ovf;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W:0]   rem_s;
  logic [ROOT_W-1:0] root;

  logic [CNT_W:0]    div_sh;
  logic [CNT_W:0]    div_sub;
  logic              div_ge;
  logic [SUM_W-1:0]  quo_step;
  logic [ROOT_W+2:0] sq_sh;
  logic [ROOT_W+2:0] sq_trial;
  logic [ROOT_W+2:0] sq_sub;
  logic              sq_ge;
  logic [ROOT_W-1:0] root_step;
  logic              div_done;
  logic              sqrt_done;
  logic              load_res;

  // one quotient bit per cycle
  assign div_sh   = {rem_d, quo[SUM_W-1]};
  assign div_sub  = div_sh - {1'b0, divisor};
  assign div_ge   = div_sh >= {1'b0, divisor};
  assign quo_step = {quo[SUM_W-2:0], div_ge};

  // one root bit per cycle, two radicand bits consumed
  assign sq_sh     = {rem_s, rad[RAD_W-1:RAD_W-2]};
  assign sq_trial  = {1'b0, root, 2'b01};
  assign sq_sub    = sq_sh - sq_trial;
  assign sq_ge     = sq_sh >= sq_trial;
  assign root_step = {root[ROOT_W-2:0], sq_ge};

  assign div_done  = step == STEP_W'(SUM_W - 1);
  assign sqrt_done = step == STEP_W'(ROOT_W - 1);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (job_valid) state_next = B_DIV;
      B_DIV:  if (div_done) state_next = B_SQRT;
      B_SQRT: if (sqrt_done) state_next = B_HOLD;
      B_HOLD: if (!result_valid || result_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    job_ready = 1'b0;
    load_res  = 1'b0;
    unique case (state)
      B_IDLE:  job_ready = 1'b1;
      B_HOLD:  load_res  = !result_valid || result_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_res) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        quo     <= job.sum;
        rem_d   <= '0;
        divisor <= job.count;
        j_count <= job.count;
        j_ovf   <= job.overflow;
        step    <= '0;
      end
      B_DIV: begin
        quo   <= quo_step;
        rem_d <= div_ge ? div_sub[CNT_W-1:0] : div_sh[CNT_W-1:0];
        if (div_done) begin
          rad   <= quo_step[RAD_W-1:0];
          rem_s <= '0;
          root  <= '0;
          step  <= '0;
        end else begin
          step <= step + 1'b1;
        end
      end
      B_SQRT: begin
        rad   <= {rad[RAD_W-3:0], 2'b00};
        rem_s <= sq_ge ? sq_sub[ROOT_W:0] : sq_sh[ROOT_W:0];
        root  <= root_step;
        step  <= step + 1'b1;
      end
      default: ;
    endcase
    if (load_res) begin
      result <= '{rms: RMS_W'(root), sample_count: COUNT_OUT_W'(j_count),
                  overflow: j_ovf};
    end
  end

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == B_DIV |-> divisor != '0)
    else $error("divide started with zero count");
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    load_res && j_ovf |-> j_count == CNT_W'(MAX_SAMPLES))
    else $error("overflow word without full window");
`endif

endmodule

// ===== hdl/true_rms_meter.sv =====
// Samples are taken one per cycle while the job queue has room; the back end works on one
// window at a time (41 divide steps, 16 root steps, load and unload) and takes the next
// only when idle, and the two-entry job queue absorbs short bursts.
// Reset is synchronous: it clears the running sum, count, queue and back-end state; no
// memory clearing pass.
module true_rms_meter import trm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic [QLVL_W-1:0] level;
  logic              push;
  job_t              push_job;
  logic              head_valid;
  logic              pop;
  job_t              head;
  logic              back_ready;

  assign pop = head_valid & back_ready;

  trm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .level      (level),
    .push       (push),
    .job        (push_job)
  );

  trm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .level      (level),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  trm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (head_valid),
    .job_ready    (back_ready),
    .job          (head),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
